FILE: rtl/tle_pkg.sv
// shared constants, byte codes and the cell command type for the terminal line editor
// no dependencies
package tle_pkg;

    localparam int LINE_SIZE_DEF = 32;

    localparam logic [7:0] C_BS     = 8'h08;
    localparam logic [7:0] C_ESC    = 8'd27;
    localparam logic [7:0] C_RIGHT  = 8'd67;
    localparam logic [7:0] C_LEFT   = 8'd68;
    localparam logic [7:0] C_INSERT = 8'd50;
    localparam logic [7:0] C_DELETE = 8'd51;
    localparam logic [7:0] C_HOME   = 8'h48;
    localparam logic [7:0] C_END    = 8'h46;
    localparam logic [7:0] C_DEL    = 8'h7f;
    localparam logic [7:0] C_BEL    = 8'h07;
    localparam logic [7:0] C_NL     = 8'h0a;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_LBRACK = 8'h5b;
    localparam logic [7:0] C_UPPERO = 8'h4f;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_ESC     = 3'd1;
    localparam logic [2:0] PH_BRACKET = 3'd2;
    localparam logic [2:0] PH_O       = 3'd3;
    localparam logic [2:0] PH_SKIP    = 3'd4;
    localparam logic [2:0] PH_DELETE  = 3'd5;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] pos;
        logic [7:0] ch;
    } cell_cmd_t;

endpackage

FILE: rtl/terminal_line_editor_core.sv
// terminal line editor: decodes keys, edits the line in a row of cells, emits echo words
// a word is taken in ST_IDLE, decoded and edited in ST_DECODE, then ST_EMIT gives one result
// per cycle unless out_stall holds the output; a word yields up to 61 results or none, and a
// new word is taken only after the previous word's last result (in_stall is high until then)
// reset: rst_n asynchronous, clears line length, cursor, insert mode and escape phase;
// the cell contents are left as they are
module terminal_line_editor_core
    import tle_pkg::*;
#(
    parameter int LINE_SIZE = LINE_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [7:0] rx_byte,
    input  logic [4:0] read_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       out_kind,
    output logic [7:0] out_byte,
    output logic       is_last,
    output logic       line_done,
    output logic [4:0] line_length
);

    localparam int         IDX_W   = (LINE_SIZE > 1) ? $clog2(LINE_SIZE) : 1;
    localparam logic [4:0] FULL_AT = 5'(LINE_SIZE - 2);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic [4:0] idx_reg;

    logic [4:0] cnt_reg, cnt_next;
    logic [4:0] cur_reg, cur_next;
    logic       ins_reg, ins_next;
    logic [2:0] ph_reg, ph_next;
    logic       closed_reg, closed_next;

    logic       pre_v_reg, pre_v_next;
    logic [7:0] pre_byte_reg, pre_byte_next;
    logic       pre_done_reg, pre_done_next;
    logic [5:0] sp_ptr_reg, sp_ptr_next;
    logic [5:0] sp_end_reg, sp_end_next;
    logic       post_v_reg, post_v_next;
    logic [4:0] bs_reg, bs_next;

    logic       ov_reg, ov_next;
    logic       okind_reg, okind_next;
    logic [7:0] obyte_reg, obyte_next;
    logic       olast_reg, olast_next;
    logic       odone_reg, odone_next;
    logic [4:0] olen_reg, olen_next;

    cell_cmd_t  cmd;
    logic [7:0] cell_q [LINE_SIZE];
    logic [7:0] span_byte;

    genvar gi;
    generate
        for (gi = 0; gi < LINE_SIZE; gi++)
        begin : g_cell
            logic [7:0] lq;
            logic [7:0] rq;
            if (gi == 0)
            begin : g_first
                assign lq = 8'h00;
            end
            else
            begin : g_left
                assign lq = cell_q[gi-1];
            end
            if (gi == LINE_SIZE - 1)
            begin : g_last
                assign rq = 8'h00;
            end
            else
            begin : g_right
                assign rq = cell_q[gi+1];
            end
            tle_cell #(.INDEX(gi)) u_cell (
                .clk     (clk),
                .cmd     (cmd),
                .left_q  (lq),
                .right_q (rq),
                .q       (cell_q[gi])
            );
        end
    endgenerate

    assign span_byte = cell_q[sp_ptr_reg[IDX_W-1:0]];

    always_comb
    begin
        logic [4:0] ec;
        logic [4:0] eu;
        logic [2:0] ph;
        logic       do_plain;
        logic       span_left;
        logic       rem;
        logic       slot_free;

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        ins_next      = ins_reg;
        ph_next       = ph_reg;
        closed_next   = closed_reg;
        pre_v_next    = pre_v_reg;
        pre_byte_next = pre_byte_reg;
        pre_done_next = pre_done_reg;
        sp_ptr_next   = sp_ptr_reg;
        sp_end_next   = sp_end_reg;
        post_v_next   = post_v_reg;
        bs_next       = bs_reg;
        ov_next       = ov_reg;
        okind_next    = okind_reg;
        obyte_next    = obyte_reg;
        olast_next    = olast_reg;
        odone_next    = odone_reg;
        olen_next     = olen_reg;
        cmd.op        = OP_HOLD;
        cmd.pos       = cur_reg;
        cmd.ch        = byte_reg;
        ec            = closed_reg ? 5'd0 : cnt_reg;
        eu            = closed_reg ? 5'd0 : cur_reg;
        ph            = closed_reg ? PH_IDLE : ph_reg;
        do_plain      = 1'b0;
        span_left     = sp_ptr_reg < sp_end_reg;
        rem           = 1'b0;
        slot_free     = !ov_reg || !out_stall;

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                pre_v_next    = 1'b0;
                pre_byte_next = 8'h00;
                pre_done_next = 1'b0;
                sp_ptr_next   = 6'd0;
                sp_end_next   = 6'd0;
                post_v_next   = 1'b0;
                bs_next       = 5'd0;
                state_next    = ST_EMIT;
                if (kind_reg)
                begin
                    if (idx_reg < cnt_reg)
                    begin
                        sp_ptr_next = {1'b0, idx_reg};
                        sp_end_next = {1'b0, idx_reg} + 6'd1;
                    end
                    else
                    begin
                        pre_v_next = 1'b1;
                    end
                end
                else
                begin
                    cnt_next    = ec;
                    cur_next    = eu;
                    closed_next = 1'b0;
                    ph_next     = PH_IDLE;
                    case (ph)
                        PH_ESC:
                        begin
                            if (byte_reg == C_LBRACK)
                                ph_next = PH_BRACKET;
                            else if (byte_reg == C_UPPERO)
                                ph_next = PH_O;
                            else if (byte_reg != C_ESC)
                                do_plain = 1'b1;
                        end
                        PH_BRACKET:
                        begin
                            if (byte_reg == C_RIGHT)
                            begin
                                if (eu < ec)
                                begin
                                    sp_ptr_next = {1'b0, eu};
                                    sp_end_next = {1'b0, eu} + 6'd1;
                                    cur_next    = eu + 5'd1;
                                end
                            end
                            else if (byte_reg == C_LEFT)
                            begin
                                pre_v_next = 1'b1;
                                if (eu > 5'd0)
                                begin
                                    pre_byte_next = C_BS;
                                    cur_next      = eu - 5'd1;
                                end
                                else
                                begin
                                    pre_byte_next = C_BEL;
                                end
                            end
                            else if (byte_reg == C_INSERT)
                            begin
                                ins_next = !ins_reg;
                                ph_next  = PH_SKIP;
                            end
                            else if (byte_reg == C_DELETE)
                            begin
                                ph_next = PH_DELETE;
                            end
                        end
                        PH_O:
                        begin
                            if (byte_reg == C_HOME)
                            begin
                                bs_next  = eu;
                                cur_next = 5'd0;
                            end
                            else if (byte_reg == C_END)
                            begin
                                sp_ptr_next = {1'b0, eu};
                                sp_end_next = {1'b0, ec};
                                cur_next    = ec;
                            end
                        end
                        PH_SKIP:
                        begin
                            ph_next = PH_IDLE;
                        end
                        PH_DELETE:
                        begin
                            if (eu < ec)
                            begin
                                cmd.op      = OP_REMOVE;
                                cmd.pos     = eu;
                                cnt_next    = ec - 5'd1;
                                sp_ptr_next = {1'b0, eu};
                                sp_end_next = {1'b0, ec - 5'd1};
                                post_v_next = 1'b1;
                                bs_next     = ec - eu;
                            end
                        end
                        default:
                        begin
                            if (byte_reg == C_ESC)
                                ph_next = PH_ESC;
                            else
                                do_plain = 1'b1;
                        end
                    endcase
                    if (do_plain)
                    begin
                        if (byte_reg == C_NL)
                        begin
                            pre_v_next    = 1'b1;
                            pre_byte_next = C_NL;
                            pre_done_next = 1'b1;
                            cmd.op        = OP_WRITE;
                            cmd.pos       = ec;
                            cnt_next      = ec + 5'd1;
                            closed_next   = 1'b1;
                        end
                        else if (byte_reg == C_DEL)
                        begin
                            if (eu > 5'd0)
                            begin
                                cmd.op        = OP_REMOVE;
                                cmd.pos       = eu - 5'd1;
                                cnt_next      = ec - 5'd1;
                                cur_next      = eu - 5'd1;
                                pre_v_next    = 1'b1;
                                pre_byte_next = C_BS;
                                sp_ptr_next   = {1'b0, eu - 5'd1};
                                sp_end_next   = {1'b0, ec - 5'd1};
                                post_v_next   = 1'b1;
                                bs_next       = ec - eu + 5'd1;
                            end
                        end
                        else if (byte_reg >= C_SPACE && byte_reg < C_DEL)
                        begin
                            pre_v_next = 1'b1;
                            if (ec < FULL_AT)
                            begin
                                pre_byte_next = byte_reg;
                                cur_next      = eu + 5'd1;
                                cmd.pos       = eu;
                                if (ins_reg)
                                begin
                                    cmd.op      = OP_INSERT;
                                    cnt_next    = ec + 5'd1;
                                    sp_ptr_next = {1'b0, eu} + 6'd1;
                                    sp_end_next = {1'b0, ec} + 6'd1;
                                    bs_next     = ec - eu;
                                end
                                else
                                begin
                                    cmd.op = OP_WRITE;
                                    if (eu == ec)
                                        cnt_next = ec + 5'd1;
                                end
                            end
                            else
                            begin
                                pre_byte_next = C_BEL;
                            end
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (!pre_v_reg && !span_left && !post_v_reg && bs_reg == 5'd0)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = kind_reg;
                    odone_next = 1'b0;
                    olen_next  = cnt_reg;
                    if (pre_v_reg)
                    begin
                        obyte_next = pre_byte_reg;
                        odone_next = pre_done_reg;
                        pre_v_next = 1'b0;
                        rem        = span_left || post_v_reg || bs_reg != 5'd0;
                    end
                    else if (span_left)
                    begin
                        obyte_next  = span_byte;
                        sp_ptr_next = sp_ptr_reg + 6'd1;
                        rem         = (sp_ptr_reg + 6'd1 < sp_end_reg) || post_v_reg
                                      || bs_reg != 5'd0;
                    end
                    else if (post_v_reg)
                    begin
                        obyte_next  = C_SPACE;
                        post_v_next = 1'b0;
                        rem         = bs_reg != 5'd0;
                    end
                    else
                    begin
                        obyte_next = C_BS;
                        bs_next    = bs_reg - 5'd1;
                        rem        = bs_reg > 5'd1;
                    end
                    olast_next = !rem;
                    if (!rem)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 5'd0;
            cur_reg    <= 5'd0;
            ins_reg    <= 1'b0;
            ph_reg     <= PH_IDLE;
            closed_reg <= 1'b0;
            pre_v_reg  <= 1'b0;
            sp_ptr_reg <= 6'd0;
            sp_end_reg <= 6'd0;
            post_v_reg <= 1'b0;
            bs_reg     <= 5'd0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cur_reg    <= cur_next;
            ins_reg    <= ins_next;
            ph_reg     <= ph_next;
            closed_reg <= closed_next;
            pre_v_reg  <= pre_v_next;
            sp_ptr_reg <= sp_ptr_next;
            sp_end_reg <= sp_end_next;
            post_v_reg <= post_v_next;
            bs_reg     <= bs_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            kind_reg <= req_type;
            byte_reg <= rx_byte;
            idx_reg  <= read_index;
        end
        pre_byte_reg <= pre_byte_next;
        pre_done_reg <= pre_done_next;
        okind_reg    <= okind_next;
        obyte_reg    <= obyte_next;
        olast_reg    <= olast_next;
        odone_reg    <= odone_next;
        olen_reg     <= olen_next;
    end

    assign in_stall    = state_reg != ST_IDLE;
    assign out_valid   = ov_reg;
    assign out_kind    = okind_reg;
    assign out_byte    = obyte_reg;
    assign is_last     = olast_reg;
    assign line_done   = odone_reg;
    assign line_length = olen_reg;

endmodule

FILE: rtl/tle_cell.sv
// one character cell of the line store, shifts with its neighbours
// depends on tle_pkg
module tle_cell
    import tle_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic       clk,
    input  cell_cmd_t  cmd,
    input  logic [7:0] left_q,
    input  logic [7:0] right_q,
    output logic [7:0] q
);

    localparam logic [4:0] IDX = 5'(INDEX);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            OP_WRITE:
            begin
                if (IDX == cmd.pos)
                    data_next = cmd.ch;
            end
            OP_INSERT:
            begin
                if (IDX == cmd.pos)
                    data_next = cmd.ch;
                else if (IDX > cmd.pos)
                    data_next = left_q;
            end
            OP_REMOVE:
            begin
                if (IDX >= cmd.pos)
                    data_next = right_q;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule
